@@ rtl/core/wkv_pkg.sv @@
package wkv_pkg;

	localparam int HEAD_SIZE_DEF  = 64;
	localparam int HEAD_COUNT_DEF = 8;
	localparam logic [6:0] HEAD_SIZE_RST = 7'd64;
	localparam logic [2:0] REG_HEAD_SIZE = 3'd0;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic        store;
		logic        last;
		logic        rd_ok;
		logic [2:0]  head;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] r;
		logic [15:0] w;
		logic [15:0] k;
		logic [15:0] v;
		logic [15:0] a;
		logic [15:0] b;
		logic [31:0] word;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic q_full;
	} back_stat_t;

	function automatic logic [31:0] rnd_sat(input logic signed [53:0] x, input int unsigned sh);
		logic signed [54:0] y;
		y = 55'(x) + (55'sd1 <<< (sh - 1));
		y = y >>> sh;
		if (y > 55'sh7fffffff)
			return 32'h7fffffff;
		else if (y < -55'sh80000000)
			return 32'h80000000;
		else
			return y[31:0];
	endfunction

endpackage

@@ rtl/core/wkv_queue.sv @@
module wkv_queue import wkv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	input  logic  pop,
	output item_t dout,
	output logic  valid,
	output logic  full
);

	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign valid = cnt_q != 2'd0;
	assign full  = cnt_q == 2'd2;
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/core/wkv_front.sv @@
module wkv_front import wkv_pkg::*; #(
	parameter int HEAD_COUNT = HEAD_COUNT_DEF
) (
	input  logic               start,
	input  logic        [1:0]  mode,
	input  logic        [2:0]  head_index,
	input  logic        [5:0]  channel,
	input  logic        [5:0]  row_index,
	input  logic signed [15:0] receptance,
	input  logic        [15:0] decay_rate,
	input  logic signed [15:0] key_elem,
	input  logic signed [15:0] value_elem,
	input  logic signed [15:0] removal_key,
	input  logic signed [15:0] replace_key,
	input  logic signed [31:0] state_word,
	input  logic               last_channel,
	input  logic        [6:0]  n,
	input  back_stat_t         stat,
	output logic               busy,
	output logic               push,
	output item_t              item
);

	logic head_ok, col_ok, row_ok, keep;

	assign busy    = stat.clearing | stat.q_full;
	assign head_ok = 7'(head_index) < 7'(HEAD_COUNT);
	assign col_ok  = {1'b0, channel} < n;
	assign row_ok  = {1'b0, row_index} < n;

	always_comb begin
		case (mode)
			MODE_LOAD:  keep = head_ok & (col_ok | last_channel);
			MODE_WRITE: keep = head_ok & col_ok & row_ok;
			MODE_READ:  keep = head_ok;
			default:    keep = 1'b0;
		endcase
	end

	assign push = start & ~busy & keep;

	always_comb begin
		item.op    = mode;
		item.store = col_ok;
		item.last  = last_channel;
		item.rd_ok = col_ok & row_ok;
		item.head  = head_index;
		item.row   = row_index;
		item.col   = channel;
		item.r     = receptance;
		item.w     = decay_rate;
		item.k     = key_elem;
		item.v     = value_elem;
		item.a     = removal_key;
		item.b     = replace_key;
		item.word  = state_word;
	end

endmodule

@@ rtl/core/wkv_back.sv @@
module wkv_back import wkv_pkg::*; #(
	parameter int HEAD_SIZE  = HEAD_SIZE_DEF,
	parameter int HEAD_COUNT = HEAD_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       it,
	input  logic        qv,
	output logic        pop,
	input  logic [6:0]  n,
	output logic        clearing,
	output logic        ov,
	output logic [31:0] oval,
	output logic [5:0]  oidx,
	output logic        olast
);

	localparam int DEPTH = HEAD_COUNT * HEAD_SIZE * HEAD_SIZE;
	localparam int SW    = $clog2(DEPTH);
	localparam int IW    = $clog2(HEAD_SIZE);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD  = 4'd2;
	localparam logic [3:0] S_UV  = 4'd3;
	localparam logic [3:0] S_UVW = 4'd4;
	localparam logic [3:0] S_P1  = 4'd5;
	localparam logic [3:0] S_P1D = 4'd6;
	localparam logic [3:0] S_P2  = 4'd7;
	localparam logic [3:0] S_P2D = 4'd8;

	function automatic logic [SW-1:0] saddr(input logic [2:0] h, input logic [5:0] r,
		input logic [5:0] c);
		return SW'(h) * SW'(HEAD_SIZE * HEAD_SIZE) + SW'(r) * SW'(HEAD_SIZE) + SW'(c);
	endfunction

	logic [31:0] smem [DEPTH];
	logic [63:0] tmain [HEAD_SIZE];
	logic [31:0] tdr [HEAD_SIZE];

	logic [3:0]    st_q;
	logic [SW-1:0] clr_q;
	logic [IW-1:0] i_q, j_q;
	logic [2:0]    head_q;
	logic [5:0]    col_q;

	logic          swe, twe, iss, p2, drained, jlast, ilast;
	logic [SW-1:0] swa, sra;
	logic [31:0]   swd, srd_q, tdr_q;
	logic [63:0]   tmain_q;
	logic [IW-1:0] twa, tra;

	logic signed [15:0] vi_q;
	logic signed [31:0] sa_q;
	logic signed [53:0] acc_q, y_q, t;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [SW-1:0]      wa_s1, wa_s2, wa_s3;
	logic signed [48:0] m1_s2;
	logic signed [31:0] m2_s2;
	logic signed [47:0] m3_s2;
	logic signed [15:0] r_s2, r_s3;
	logic signed [31:0] s_s3;
	logic signed [47:0] yp_s4;
	logic signed [16:0] op2;

	assign clearing = st_q == S_CLR;
	assign p2       = (st_q == S_P2) || (st_q == S_P2D);
	assign drained  = ~(v_s1 | v_s2 | v_s3 | v_s4);
	assign jlast    = 7'(j_q) == n - 7'd1;
	assign ilast    = 7'(i_q) == n - 7'd1;
	assign pop      = (st_q == S_IDLE) & qv;
	assign iss      = (st_q == S_P1) || (st_q == S_P2);
	assign twe      = pop & (it.op == MODE_LOAD) & it.store;
	assign twa      = it.col[IW-1:0];

	always_comb begin
		swe = 1'b0;
		swa = saddr(it.head, it.row, it.col);
		swd = it.word;
		sra = saddr(it.head, it.row, it.col);
		tra = j_q;
		case (st_q)
			S_CLR: begin
				swe = 1'b1;
				swa = clr_q;
				swd = 32'd0;
			end
			S_IDLE: begin
				swe = pop & (it.op == MODE_WRITE);
			end
			S_UV: begin
				tra = i_q;
			end
			S_P1, S_P2, S_P2D: begin
				sra = saddr(head_q, 6'(i_q), 6'(j_q));
				swe = p2 & v_s3;
				swa = wa_s3;
				swd = s_s3;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (swe)
			smem[swa] <= swd;
		srd_q <= smem[sra];
	end

	always_ff @(posedge clk) begin
		if (twe) begin
			tmain[twa] <= {it.a, it.v, it.k, it.r};
			tdr[twa]   <= {it.b, it.w};
		end
		tmain_q <= tmain[tra];
		tdr_q   <= tdr[tra];
	end

	assign op2 = p2 ? signed'({1'b0, tdr_q[15:0]}) : signed'({tmain_q[63], tmain_q[63:48]});
	assign t   = 54'(m1_s2) + (54'(m2_s2) <<< 8) + (54'(m3_s2) <<< 4);

	always_ff @(posedge clk) begin
		wa_s1 <= sra;
		wa_s2 <= wa_s1;
		wa_s3 <= wa_s2;
		m1_s2 <= signed'(srd_q) * op2;
		m2_s2 <= vi_q * signed'(tmain_q[31:16]);
		m3_s2 <= sa_q * signed'(tdr_q[31:16]);
		r_s2  <= signed'(tmain_q[15:0]);
		r_s3  <= r_s2;
		s_s3  <= signed'(rnd_sat(t, 16));
		yp_s4 <= s_s3 * r_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLR;
			clr_q  <= '0;
			i_q    <= '0;
			j_q    <= '0;
			head_q <= '0;
			col_q  <= '0;
			vi_q   <= '0;
			sa_q   <= '0;
			acc_q  <= '0;
			y_q    <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ov     <= 1'b0;
			oval   <= '0;
			oidx   <= '0;
			olast  <= 1'b0;
		end else begin
			ov   <= 1'b0;
			v_s1 <= iss;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s2 && !p2)
				acc_q <= acc_q + 54'(m1_s2);
			if (v_s4 && p2)
				y_q <= y_q + 54'(yp_s4);
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(DEPTH - 1))
						st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						col_q  <= it.col;
						head_q <= it.head;
						case (it.op)
							MODE_LOAD: begin
								if (it.last) begin
									i_q  <= '0;
									st_q <= S_UV;
								end
							end
							MODE_READ: begin
								if (it.rd_ok)
									st_q <= S_RD;
								else begin
									ov    <= 1'b1;
									oval  <= '0;
									oidx  <= it.col;
									olast <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					ov    <= 1'b1;
					oval  <= srd_q;
					oidx  <= col_q;
					olast <= 1'b1;
					st_q  <= S_IDLE;
				end
				S_UV: begin
					j_q  <= '0;
					st_q <= S_UVW;
				end
				S_UVW: begin
					vi_q  <= signed'(tmain_q[47:32]);
					acc_q <= '0;
					st_q  <= S_P1;
				end
				S_P1: begin
					j_q <= j_q + 1'b1;
					if (jlast)
						st_q <= S_P1D;
				end
				S_P1D: begin
					if (drained) begin
						sa_q <= signed'(rnd_sat(acc_q, 12));
						j_q  <= '0;
						y_q  <= '0;
						st_q <= S_P2;
					end
				end
				S_P2: begin
					j_q <= j_q + 1'b1;
					if (jlast)
						st_q <= S_P2D;
				end
				S_P2D: begin
					if (drained) begin
						ov    <= 1'b1;
						oval  <= rnd_sat(y_q, 12);
						oidx  <= 6'(i_q);
						olast <= ilast;
						i_q   <= i_q + 1'b1;
						st_q  <= ilast ? S_IDLE : S_UV;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLR |-> !ov && !pop)
		else $error("activity during clearing pass");
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> drained)
		else $error("pipeline busy while idle");
	a_p1_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_P1 || st_q == S_P1D) |-> !swe)
		else $error("state write during row dot pass");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qv)
		else $error("pop from empty queue");

endmodule

@@ rtl/core/wkv_state_update_top.sv @@
// Mode 0 items without last_channel and mode 1 items leave the back end idle, so it can take the next item at once.
// In-range mode 2 reads go via the queue, a RAM read and S_RD; bad row/column reads return 0.
// An update run processes n rows, each through a row dot pass and an update pass.
// Reset starts a clearing pass over all HEAD_COUNT*HEAD_SIZE*HEAD_SIZE state words with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module wkv_state_update_top import wkv_pkg::*; #(
	parameter int HEAD_SIZE  = HEAD_SIZE_DEF,
	parameter int HEAD_COUNT = HEAD_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic        [1:0]  mode,
	input  logic        [2:0]  head_index,
	input  logic        [5:0]  channel,
	input  logic        [5:0]  row_index,
	input  logic signed [15:0] receptance,
	input  logic        [15:0] decay_rate,
	input  logic signed [15:0] key_elem,
	input  logic signed [15:0] value_elem,
	input  logic signed [15:0] removal_key,
	input  logic signed [15:0] replace_key,
	input  logic signed [31:0] state_word,
	input  logic               last_channel,
	output logic               result_valid,
	output logic signed [31:0] out_value,
	output logic        [5:0]  out_index,
	output logic               out_last
);

	logic [6:0] head_size_q, n;
	logic       push, pop, qv, full, clearing;
	item_t      item_in, item_out;
	back_stat_t stat;
	logic [31:0] oval;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_HEAD_SIZE) ? {25'd0, head_size_q} : 32'd0;
	assign n = (head_size_q == 7'd0) ? 7'd1 :
		(head_size_q > 7'(HEAD_SIZE)) ? 7'(HEAD_SIZE) : head_size_q;
	assign stat.clearing = clearing;
	assign stat.q_full   = full;
	assign out_value     = signed'(oval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			head_size_q <= HEAD_SIZE_RST;
		else if (psel && penable && pwrite && paddr == REG_HEAD_SIZE)
			head_size_q <= pwdata[6:0];
	end

	wkv_front #(.HEAD_COUNT(HEAD_COUNT)) u_front (
		.start(start), .mode(mode), .head_index(head_index), .channel(channel),
		.row_index(row_index), .receptance(receptance), .decay_rate(decay_rate),
		.key_elem(key_elem), .value_elem(value_elem), .removal_key(removal_key),
		.replace_key(replace_key), .state_word(state_word), .last_channel(last_channel),
		.n(n), .stat(stat), .busy(busy), .push(push), .item(item_in)
	);

	wkv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(item_in), .pop(pop),
		.dout(item_out), .valid(qv), .full(full)
	);

	wkv_back #(.HEAD_SIZE(HEAD_SIZE), .HEAD_COUNT(HEAD_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .it(item_out), .qv(qv), .pop(pop), .n(n),
		.clearing(clearing), .ov(result_valid), .oval(oval), .oidx(out_index),
		.olast(out_last)
	);

endmodule

@@ tb/wkv_state_update_top_tb.sv @@
module wkv_state_update_top_tb;
	import wkv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NH = HEAD_COUNT_DEF;
	localparam int NS = HEAD_SIZE_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]         mode;
		logic [2:0]         head;
		logic [5:0]         chan;
		logic [5:0]         row;
		logic signed [15:0] r, k, v, a, b;
		logic [15:0]        w;
		logic signed [31:0] word;
		logic               last;
	} request_t;

	typedef struct {
		logic signed [31:0] value;
		logic [5:0]         index;
		logic               last;
	} wkv_out_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy;
	logic [1:0] mode;
	logic [2:0] head_index;
	logic [5:0] channel, row_index;
	logic signed [15:0] receptance, key_elem, value_elem, removal_key, replace_key;
	logic [15:0] decay_rate;
	logic signed [31:0] state_word;
	logic last_channel;
	logic result_valid;
	logic signed [31:0] out_value;
	logic [5:0] out_index;
	logic out_last;

	wkv_state_update_top u_top (.*);

	logic signed [31:0] st_mat [NH][NS][NS];
	logic signed [15:0] tok_r [NS], tok_k [NS], tok_v [NS], tok_a [NS], tok_b [NS];
	logic [15:0]        tok_w [NS];
	bit                 loaded [NS];
	logic [6:0]         head_size_cfg;
	wkv_out_t           wkv_expected [$];
	int                 errors, requests_sent, results_seen, tokens_run, cyc;
	bit                 quiet;

	always begin
		clk = 0;
		#5;
		clk = 1;
		#5;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		wkv_out_t e;
		if (arst_n && result_valid) begin
			results_seen++;
			if (wkv_expected.size() == 0) begin
				$error("unexpected result value=%0d index=%0d", out_value, out_index);
				errors++;
			end else begin
				e = wkv_expected.pop_front();
				if (out_value !== e.value) begin
					$error("out_value exp %0d got %0d", e.value, out_value);
					errors++;
				end
				if (out_index !== e.index) begin
					$error("out_index exp %0d got %0d", e.index, out_index);
					errors++;
				end
				if (out_last !== e.last) begin
					$error("out_last exp %0d got %0d", e.last, out_last);
					errors++;
				end
			end
		end
	end

	function automatic int eff_n();
		if (head_size_cfg < 1) return 1;
		if (head_size_cfg > NS) return NS;
		return int'(head_size_cfg);
	endfunction

	function automatic longint rnd_floor(longint x, int sh);
		return (x + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	task automatic run_recurrence(int h);
		int n;
		longint acc, y, sa, vi, t;
		logic signed [31:0] s;
		wkv_out_t e;
		n = eff_n();
		tokens_run++;
		for (int i = 0; i < n; i++) begin
			acc = 0;
			y = 0;
			vi = longint'(tok_v[i]);
			for (int j = 0; j < n; j++)
				acc += longint'(st_mat[h][i][j]) * longint'(tok_a[j]);
			sa = longint'(clamp32(rnd_floor(acc, 12)));
			for (int j = 0; j < n; j++) begin
				t = longint'(st_mat[h][i][j]) * longint'({1'b0, tok_w[j]})
					+ vi * longint'(tok_k[j]) * 256 + sa * longint'(tok_b[j]) * 16;
				s = clamp32(rnd_floor(t, 16));
				st_mat[h][i][j] = s;
				y += longint'(s) * longint'(tok_r[j]);
			end
			e.value = clamp32(rnd_floor(y, 12));
			e.index = 6'(i);
			e.last = (i == n - 1);
			wkv_expected.push_back(e);
		end
	endtask

	task automatic predict_request(request_t q);
		int n;
		wkv_out_t e;
		n = eff_n();
		if (int'(q.head) >= NH) return;
		case (q.mode)
			MODE_LOAD: begin
				if (q.chan < n) begin
					tok_r[q.chan] = q.r;
					tok_w[q.chan] = q.w;
					tok_k[q.chan] = q.k;
					tok_v[q.chan] = q.v;
					tok_a[q.chan] = q.a;
					tok_b[q.chan] = q.b;
					loaded[q.chan] = 1;
				end
				if (q.last) run_recurrence(q.head);
			end
			MODE_WRITE: begin
				if (q.row < n && q.chan < n) st_mat[q.head][q.row][q.chan] = q.word;
			end
			MODE_READ: begin
				e.value = (q.row < n && q.chan < n) ? st_mat[q.head][q.row][q.chan] : 32'sd0;
				e.index = q.chan;
				e.last = 1;
				wkv_expected.push_back(e);
			end
			default: ;
		endcase
	endtask

	task automatic send_request(request_t q);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		start = 1;
		mode = q.mode;
		head_index = q.head;
		channel = q.chan;
		row_index = q.row;
		receptance = q.r;
		decay_rate = q.w;
		key_elem = q.k;
		value_elem = q.v;
		removal_key = q.a;
		replace_key = q.b;
		state_word = q.word;
		last_channel = q.last;
		do @(posedge clk); while (busy);
		requests_sent++;
		predict_request(q);
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		start = 0;
		wait (wkv_expected.size() == 0);
		do @(posedge clk); while (busy);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_head_size(logic [6:0] val);
		drain_and_settle();
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = 3'(REG_HEAD_SIZE) << 2;
		pwdata = 32'(val);
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		head_size_cfg = val;
	endtask

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic request_t rand_load(int ch, bit last);
		request_t q;
		q.mode = MODE_LOAD;
		q.head = 3'($urandom_range(0, NH - 1));
		q.chan = 6'(ch);
		q.row = 6'($urandom);
		q.r = rand16();
		q.w = rand16();
		q.k = rand16();
		q.v = rand16();
		q.a = rand16();
		q.b = rand16();
		q.word = 32'($urandom);
		q.last = last;
		return q;
	endfunction

	task automatic send_token(int h);
		request_t q;
		int n;
		n = eff_n();
		for (int j = 0; j < n; j++) begin
			q = rand_load(j, j == n - 1);
			q.head = 3'(h);
			send_request(q);
		end
	endtask

	task automatic access_word(logic [1:0] md, int h, int rw, int cl, logic [31:0] wd);
		request_t q;
		q = rand_load(cl, 0);
		q.mode = md;
		q.head = 3'(h);
		q.row = 6'(rw);
		q.word = wd;
		send_request(q);
	endtask

	task automatic test_reset_readback();
		access_word(MODE_READ, 0, 0, 0, 0);
		access_word(MODE_READ, NH - 1, NS - 1, NS - 1, 0);
	endtask

	task automatic test_full_head();
		send_token(7);
		access_word(MODE_READ, 7, 63, 0, 0);
	endtask

	task automatic test_word_access();
		write_head_size(7'd4);
		access_word(MODE_WRITE, 1, 0, 0, 32'h7fffffff);
		access_word(MODE_WRITE, 1, 3, 3, 32'h80000000);
		access_word(MODE_WRITE, 1, 4, 0, 32'h12345678);
		access_word(MODE_WRITE, 1, 0, 63, 32'h12345678);
		access_word(MODE_READ, 1, 0, 0, 0);
		access_word(MODE_READ, 1, 3, 3, 0);
		access_word(MODE_READ, 1, 4, 0, 0);
		access_word(MODE_READ, 1, 63, 63, 0);
		access_word(2'd3, 1, 0, 0, 0);
		send_token(1);
		access_word(MODE_READ, 1, 0, 0, 0);
	endtask

	task automatic test_size_extremes();
		request_t q;
		write_head_size(7'd0);
		send_token(2);
		q = rand_load(40, 1);
		send_request(q);
		write_head_size(7'd127);
		access_word(MODE_READ, 7, 63, 63, 0);
		write_head_size(7'd65);
		q = rand_load(63, 1);
		q.head = 3'd5;
		send_request(q);
	endtask

	task automatic test_random_traffic();
		request_t q;
		int n;
		bit ok;
		int sizes [6] = '{1, 2, 3, 5, 7, 8};
		write_head_size(7'(sizes[$urandom_range(0, 5)]));
		for (int it = 0; it < 85; it++) begin
			if (it > 65) quiet = 1;
			if (it % 30 == 29) begin
				write_head_size(7'(sizes[$urandom_range(0, 5)]));
			end
			if (it == 40) drain_and_settle();
			n = eff_n();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_token($urandom_range(0, NH - 1));
					it += n - 1;
				end
				4: access_word(MODE_WRITE, $urandom_range(0, NH - 1), $urandom_range(0, n),
					$urandom_range(0, n), (($urandom & 1) ? 32'($urandom) : 32'h80000000));
				5, 6: access_word(MODE_READ, $urandom_range(0, NH - 1),
					$urandom_range(0, n), $urandom_range(0, n), 0);
				7: access_word(2'd3, $urandom_range(0, NH - 1), 0, 0, 0);
				default: begin
					q = rand_load($urandom_range(0, 63), $urandom_range(0, 1));
					ok = 1;
					for (int j = 0; j < n; j++) ok &= loaded[j];
					if (!ok) q.last = 0;
					send_request(q);
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		mode = MODE_LOAD;
		head_index = 0;
		channel = 0;
		row_index = 0;
		receptance = 0;
		decay_rate = 0;
		key_elem = 0;
		value_elem = 0;
		removal_key = 0;
		replace_key = 0;
		state_word = 0;
		last_channel = 0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		tokens_run = 0;
		cyc = 0;
		quiet = 0;
		head_size_cfg = HEAD_SIZE_RST;
		foreach (st_mat[h, i, j]) st_mat[h][i][j] = 0;
		foreach (loaded[j]) loaded[j] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_reset_readback();
		test_full_head();
		test_word_access();
		test_size_extremes();
		test_random_traffic();

		@(negedge clk);
		start = 0;
		wait (wkv_expected.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d requests, %0d recurrence runs, %0d results checked",
			requests_sent, tokens_run, results_seen);
		$display("head sizes swept from 0 to 127, word access in and out of range");
		if (errors == 0 && wkv_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/wkv_pkg.sv
rtl/core/wkv_queue.sv
rtl/core/wkv_front.sv
rtl/core/wkv_back.sv
rtl/core/wkv_state_update_top.sv
tb/wkv_state_update_top_tb.sv
